/* rtl/infix_to_postfix_converter_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter
// Clocked on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH

// Property checked at every rising edge of clk_i.
`define ITPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ITPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/itpc_pkg.sv */
// ----------------------------------------------------------------------------
// itpc_pkg
// Types, codes and helpers shared by the infix-to-postfix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itpc_pkg;

  localparam int StackDepthDef = 32;
  localparam int QueueDepth    = 2;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;

  // Stack entry codes
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_OPEN = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    K_PASS,
    K_MULDIV,
    K_ADDSUB,
    K_OPEN,
    K_CLOSE,
    K_END
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_CLOSE     = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_OPEN_LEFT = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_RELOAD
  } state_e;

  // Classified beat handed from front to back
  typedef struct packed {
    kind_e      kind;
    op_e        code;
    logic [7:0] sym;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [7:0] sym;
    logic       sym_valid;
    logic       last;
    logic       done;
    err_e       err;
  } res_t;

  function automatic logic [7:0] op_char(op_e op);
    logic [7:0] ch;
    case (op)
      OP_ADD:  ch = ChPlus;
      OP_SUB:  ch = ChMinus;
      OP_MUL:  ch = ChStar;
      OP_DIV:  ch = ChSlash;
      OP_OPEN: ch = ChOpen;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/itpc_ram.sv */
// ----------------------------------------------------------------------------
// itpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itpc_ram #(
  parameter int Width = 3,
  parameter int Depth = 32,
  localparam int Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/itpc_front.sv */
// ----------------------------------------------------------------------------
// itpc_front
// Input side: takes character beats and classifies them into commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itpc_front (
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   symbol_i,
  input  wire logic         end_of_input_i,
  input  wire logic         q_full_i,
  output logic              q_push_o,
  output itpc_pkg::cmd_t    q_cmd_o
);

  import itpc_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.sym  = symbol_i;
    q_cmd_o.kind = K_PASS;
    q_cmd_o.code = OP_ADD;
    if (end_of_input_i) begin
      q_cmd_o.kind = K_END;
    end else begin
      case (symbol_i)
        ChStar:  begin q_cmd_o.kind = K_MULDIV; q_cmd_o.code = OP_MUL;  end
        ChSlash: begin q_cmd_o.kind = K_MULDIV; q_cmd_o.code = OP_DIV;  end
        ChPlus:  begin q_cmd_o.kind = K_ADDSUB; q_cmd_o.code = OP_ADD;  end
        ChMinus: begin q_cmd_o.kind = K_ADDSUB; q_cmd_o.code = OP_SUB;  end
        ChOpen:  begin q_cmd_o.kind = K_OPEN;   q_cmd_o.code = OP_OPEN; end
        ChClose: begin q_cmd_o.kind = K_CLOSE;  end
        default: begin q_cmd_o.kind = K_PASS;   end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/itpc_fifo.sv */
// ----------------------------------------------------------------------------
// itpc_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itpc_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  itpc_pkg::cmd_t      cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output itpc_pkg::cmd_t      cmd_o
);

  import itpc_pkg::*;

  localparam int Pw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int Cw = $clog2(QueueDepth + 1);

  cmd_t          buf_q [QueueDepth];
  logic [Pw-1:0] wr_ptr_q, wr_ptr_d;
  logic [Pw-1:0] rd_ptr_q, rd_ptr_d;
  logic [Cw-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == Cw'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Pw'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Pw'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/itpc_back.sv */
// ----------------------------------------------------------------------------
// itpc_back
// Execution side: operator stack sequencer and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_core_defines.svh"

module itpc_back #(
  parameter int STACK_DEPTH = itpc_pkg::StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  itpc_pkg::cmd_t   cmd_i,
  output logic             cmd_deq_o,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output itpc_pkg::res_t   res_o
);

  import itpc_pkg::*;

  localparam int Lw = $clog2(STACK_DEPTH + 1);
  localparam int Aw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  state_e        state_q, state_d;
  cmd_t          cmd_q;
  logic [Lw-1:0] level_q;
  op_e           top_q;
  logic          pend_v_q;
  logic [7:0]    pend_char_q;
  logic          err_open_q;
  logic          out_valid_q;
  res_t          res_q;

  logic          out_free;
  logic          loop_pop, has_final, full, empty;
  res_t          final_res;

  // Actions decided in the output block
  logic          emit;
  res_t          emit_res;
  logic          pend_set, pend_clr;
  logic          lvl_dec, lvl_inc, ram_we;
  logic          err_set, err_clr;
  logic          finish, go_load, go_reload;

  logic [Lw-1:0] raddr_full;
  logic [2:0]    rdata;

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (level_q == Lw'(STACK_DEPTH));
  assign empty    = (level_q == '0);

  // Entry below the current top; loaded into top_q after a pop
  assign raddr_full = (level_q >= Lw'(2)) ? level_q - Lw'(2) : '0;

  itpc_ram #(
    .Width (3),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (level_q[Aw-1:0]),
    .wdata_i (cmd_q.code),
    .raddr_i (raddr_full[Aw-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    loop_pop = 1'b0;
    if (!empty) begin
      case (cmd_q.kind)
        K_MULDIV: loop_pop = (top_q inside {OP_MUL, OP_DIV});
        K_ADDSUB,
        K_CLOSE:  loop_pop = (top_q != OP_OPEN);
        K_END:    loop_pop = 1'b1;
        default:  loop_pop = 1'b0;
      endcase
    end
  end

  // Result that closes the command, if it has one
  always_comb begin
    final_res           = '0;
    final_res.last      = 1'b1;
    final_res.err       = ERR_OK;
    has_final           = 1'b0;
    case (cmd_q.kind)
      K_PASS: begin
        has_final           = 1'b1;
        final_res.sym       = cmd_q.sym;
        final_res.sym_valid = 1'b1;
      end
      K_MULDIV, K_ADDSUB, K_OPEN: begin
        has_final     = full;
        final_res.err = ERR_OVERFLOW;
      end
      K_CLOSE: begin
        has_final     = empty;
        final_res.err = ERR_CLOSE;
      end
      K_END: begin
        has_final      = 1'b1;
        final_res.done = 1'b1;
        final_res.err  = err_open_q ? ERR_OPEN_LEFT : ERR_OK;
      end
      default: has_final = 1'b0;
    endcase
  end

  // Output block
  always_comb begin
    cmd_deq_o          = 1'b0;
    emit               = 1'b0;
    emit_res           = '0;
    emit_res.err       = ERR_OK;
    emit_res.sym       = pend_char_q;
    emit_res.sym_valid = 1'b1;
    pend_set           = 1'b0;
    pend_clr           = 1'b0;
    lvl_dec            = 1'b0;
    lvl_inc            = 1'b0;
    ram_we             = 1'b0;
    err_set            = 1'b0;
    err_clr            = 1'b0;
    finish             = 1'b0;
    go_load            = 1'b0;
    go_reload          = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_deq_o = cmd_valid_i;
      end
      S_EXEC: begin
        if (loop_pop) begin
          if (cmd_q.kind == K_END && top_q == OP_OPEN) begin
            lvl_dec = 1'b1;
            err_set = 1'b1;
            go_load = 1'b1;
          end else if (!pend_v_q || out_free) begin
            // a held pop goes out now; the new one waits to learn if it is last
            emit     = pend_v_q;
            pend_set = 1'b1;
            lvl_dec  = 1'b1;
            go_load  = 1'b1;
          end
        end else if (has_final) begin
          if (out_free) begin
            if (pend_v_q) begin
              emit     = 1'b1;
              pend_clr = 1'b1;
            end else begin
              emit     = 1'b1;
              emit_res = final_res;
              finish   = 1'b1;
              err_clr  = 1'b1;
            end
          end
        end else if (!pend_v_q || out_free) begin
          emit          = pend_v_q;
          emit_res.last = 1'b1;
          pend_clr      = 1'b1;
          if (cmd_q.kind == K_CLOSE) begin
            lvl_dec   = 1'b1;
            go_reload = 1'b1;
          end else begin
            ram_we  = 1'b1;
            lvl_inc = 1'b1;
            finish  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next state block
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (cmd_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (go_load) begin
          state_d = S_LOAD;
        end else if (go_reload) begin
          state_d = S_RELOAD;
        end else if (finish) begin
          state_d = S_IDLE;
        end
      end
      S_LOAD:   state_d = S_EXEC;
      S_RELOAD: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      pend_v_q    <= 1'b0;
      err_open_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (lvl_dec) begin
        level_q <= level_q - 1'b1;
      end else if (lvl_inc) begin
        level_q <= level_q + 1'b1;
      end
      if (pend_set) begin
        pend_v_q <= 1'b1;
      end else if (pend_clr) begin
        pend_v_q <= 1'b0;
      end
      if (err_set) begin
        err_open_q <= 1'b1;
      end else if (err_clr) begin
        err_open_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_deq_o) begin
      cmd_q <= cmd_i;
    end
    if (ram_we) begin
      top_q <= cmd_q.code;
    end else if (state_q == S_LOAD || state_q == S_RELOAD) begin
      top_q <= op_e'(rdata);
    end
    if (pend_set) begin
      pend_char_q <= op_char(top_q);
    end
    if (emit) begin
      res_q <= emit_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `ITPC_ASSERT(a_level_range, level_q <= Lw'(STACK_DEPTH), "stack level past depth")
  `ITPC_ASSERT(a_push_room, ram_we |-> !full, "push onto full stack")
  `ITPC_ASSERT_NEXT(a_pop_reload, go_load, state_q == S_LOAD, "pop not followed by top reload")
  `ITPC_ASSERT(a_idle_no_pend, (state_q == S_IDLE) |-> !pend_v_q, "held pop left at command end")
  `ITPC_ASSERT(a_idle_no_err, (state_q == S_IDLE) |-> !err_open_q, "open-paren flag left set")

endmodule

`default_nettype wire

/* rtl/infix_to_postfix_converter_core.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// An input beat is written into the command queue, taken into the command
//   register, and its result is then registered in the output register. A new
//   command is taken only when the last is done; every pop from the operator
//   stack passes through S_LOAD (registered stack RAM read reloads the top), and a
//   matched close paren through S_RELOAD. Output stalls can hold any of these.
// Reset: asynchronous, active low; stack level, queue and output clear at once.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = itpc_pkg::StackDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_symbol_o,
  output logic            symbol_valid_o,
  output logic            run_last_o,
  output logic            expression_done_o,
  output logic [1:0]      error_code_o
);

  import itpc_pkg::*;

  cmd_t fr_cmd, q_cmd;
  logic q_full, q_push, q_valid, q_pop;
  res_t res;

  itpc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_i       (symbol_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (fr_cmd)
  );

  itpc_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (fr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  itpc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_deq_o   (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign out_symbol_o      = res.sym;
  assign symbol_valid_o    = res.sym_valid;
  assign run_last_o        = res.last;
  assign expression_done_o = res.done;
  assign error_code_o      = res.err;

endmodule

`default_nettype wire
